>>> sv/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // read address select
  localparam logic [1:0] RD_HEAD   = 2'd0;
  localparam logic [1:0] RD_IDX_M1 = 2'd1;
  localparam logic [1:0] RD_IDX_M2 = 2'd2;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] in_data;
    logic signed [31:0] in_priority;
  } in_item_t;

  typedef struct packed {
    logic               out_valid;
    logic signed [31:0] out_data;
    logic signed [31:0] out_priority;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       shift;
    logic       place;
    logic       deq_take;
    logic       res_full;
    logic       res_empty;
    logic       out_load;
  } spq_cmd_t;

  typedef struct packed {
    logic is_enq;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_one;
    logic cmp_ge;
  } spq_stat_t;

endpackage

>>> sv/spq_dp.sv
module spq_dp #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::in_item_t  in_item,
  input  spq_pkg::spq_cmd_t  cmd,
  output spq_pkg::spq_stat_t stat,
  output spq_pkg::out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::entry_t    mem [DEPTH];
  spq_pkg::entry_t    rd_data_r;
  spq_pkg::in_item_t  item_r;
  spq_pkg::out_item_t res_r;
  spq_pkg::out_item_t out_r;

  logic [AW-1:0] head_r;
  logic [AW-1:0] head_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] idx_r;

  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;
  spq_pkg::entry_t wr_data;

  // slot k of the sorted order lives at head + k, wrapped around the ring
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(k);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    unique case (cmd.rd_sel)
      spq_pkg::RD_IDX_M1: rd_addr = phys(head_r, idx_r - 1'b1);
      spq_pkg::RD_IDX_M2: rd_addr = phys(head_r, idx_r - 2'd2);
      default:            rd_addr = head_r;
    endcase
  end

  assign wr_en   = cmd.shift | cmd.place;
  assign wr_addr = phys(head_r, idx_r);
  always_comb begin
    if (cmd.place) begin
      wr_data.data = item_r.in_data;
      wr_data.prio = item_r.in_priority;
    end else begin
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.place) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.deq_take) begin
      count_nxt = count_r - 1'b1;
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      idx_r  <= count_r;
    end else if (cmd.shift) begin
      idx_r <= idx_r - 1'b1;
    end

    if (cmd.place) begin
      res_r.out_valid    <= 1'b0;
      res_r.out_data     <= '0;
      res_r.out_priority <= '0;
      res_r.status       <= spq_pkg::ST_OK;
      res_r.occupancy    <= 5'(count_nxt);
    end else if (cmd.deq_take) begin
      res_r.out_valid    <= 1'b1;
      res_r.out_data     <= rd_data_r.data;
      res_r.out_priority <= rd_data_r.prio;
      res_r.status       <= spq_pkg::ST_OK;
      res_r.occupancy    <= 5'(count_nxt);
    end else if (cmd.res_full || cmd.res_empty) begin
      res_r.out_valid    <= 1'b0;
      res_r.out_data     <= '0;
      res_r.out_priority <= '0;
      res_r.status       <= cmd.res_full ? spq_pkg::ST_FULL : spq_pkg::ST_EMPTY;
      res_r.occupancy    <= 5'(count_r);
    end

    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign stat.is_enq   = (item_r.cmd == spq_pkg::CMD_ENQ);
  assign stat.full     = (count_r == CW'(DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.idx_one  = (idx_r == CW'(1));
  assign stat.cmp_ge   = (rd_data_r.prio >= item_r.in_priority);

  assign out_item = out_r;

endmodule

>>> sv/spq_ctrl.sv
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_DEQ    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_vld_r;
  logic       out_vld_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_enq) begin
          if (stat.full) begin
            cmd.res_full = 1'b1;
            state_nxt    = S_FIN;
          end else if (stat.idx_zero) begin
            cmd.place = 1'b1;
            state_nxt = S_FIN;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spq_pkg::RD_IDX_M1;
            state_nxt  = S_SCAN;
          end
        end else if (stat.empty) begin
          cmd.res_empty = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = spq_pkg::RD_HEAD;
          state_nxt  = S_DEQ;
        end
      end
      S_SCAN: begin
        // move the entry below one slot up while it does not outrank the new one
        if (stat.cmp_ge) begin
          cmd.shift = 1'b1;
          if (stat.idx_one) begin
            state_nxt = S_PLACE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = spq_pkg::RD_IDX_M2;
          end
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FIN;
      end
      S_DEQ: begin
        cmd.deq_take = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

>>> sv/sorted_priority_queue.sv
// Sorted min-priority queue on a ring buffer memory, one operation at a time.
// A dequeue takes the head entry. An enqueue moves each stored entry with priority >= the
// new one up one slot per cycle, then places the new entry; into an empty queue it is
// placed directly. A full enqueue or an empty dequeue only reports its status. The next
// input can be taken in the same cycle as result valid; a result waiting at the output
// does not hold off that input. Synchronous reset empties the queue at once.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_item
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

>>> tb/spq_checker.sv
`timescale 1ns / 100ps

module spq_checker #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  spq_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  spq_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 outstanding
);

  // sorted contents, slot 0 leaves next
  logic signed [31:0] held_data [DEPTH];
  logic signed [31:0] held_prio [DEPTH];
  int                 held_count = 0;
  spq_pkg::out_item_t pending_results [$];
  int                 fail_n = 0;
  spq_pkg::out_item_t want;

  function automatic spq_pkg::out_item_t serve_op(input spq_pkg::in_item_t op);
    spq_pkg::out_item_t res;
    int                 pos;
    bit                 found;
    logic signed [31:0] p;
    res   = '0;
    p     = op.in_priority;
    found = 1'b0;
    if (op.cmd == spq_pkg::CMD_ENQ) begin
      if (held_count >= DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        pos = held_count;
        // place ahead of the first entry with priority >= new one
        for (int i = 0; i < held_count; i++) begin
          if (!found && held_prio[i] >= p) begin
            pos   = i;
            found = 1'b1;
          end
        end
        for (int i = held_count; i > pos; i--) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_data[pos] = op.in_data;
        held_prio[pos] = p;
        held_count++;
        res.status = spq_pkg::ST_OK;
      end
    end else begin
      if (held_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.out_valid    = 1'b1;
        res.out_data     = held_data[0];
        res.out_priority = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_data[i-1] = held_data[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
        res.status = spq_pkg::ST_OK;
      end
    end
    res.occupancy = held_count[4:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(serve_op(in_item));
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          fail_n++;
          if (fail_n <= 10) begin
            $display("%0t: result with nothing expected: valid=%0d data=%h prio=%h st=%0d occ=%0d",
                     $realtime, out_item.out_valid, out_item.out_data,
                     out_item.out_priority, out_item.status, out_item.occupancy);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_item !== want) begin
            fail_n++;
            if (fail_n <= 10) begin
              $display("%0t: mismatch exp valid=%0d data=%h prio=%h st=%0d occ=%0d",
                       $realtime, want.out_valid, want.out_data, want.out_priority,
                       want.status, want.occupancy);
              $display("%0t:          got valid=%0d data=%h prio=%h st=%0d occ=%0d",
                       $realtime, out_item.out_valid, out_item.out_data,
                       out_item.out_priority, out_item.status, out_item.occupancy);
            end
          end
        end
      end
    end
    mismatches  <= fail_n;
    outstanding <= pending_results.size();
  end

endmodule

>>> tb/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

  localparam int DEPTH     = spq_pkg::DEPTH_DEF;
  localparam int LONG_HOLD = 300;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  spq_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  spq_pkg::out_item_t out_item;

  int mismatches;
  int outstanding;
  int n_sent     = 0;
  bit tx_gaps    = 1'b1;
  bit quiet_tail = 1'b0;
  bit hold_req   = 1'b0;

  always #5 clk = ~clk;

  sorted_priority_queue #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  spq_checker #(.DEPTH(DEPTH)) order_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic logic [31:0] pick_prio(input int mode);
    logic [31:0] edges [6];
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
              32'h8000_0001, 32'h7FFF_FFFE};
    case (mode)
      0:       return $urandom;
      1:       return 32'($urandom_range(0, 6)) - 32'd3;  // dense ties around zero
      default: return edges[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic logic [31:0] pick_data();
    if ($urandom_range(0, 7) == 0) begin
      return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return $urandom;
  endfunction

  task automatic pause(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    in_item  <= {1'($urandom_range(0, 1)), $urandom, $urandom};
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send(input logic cmd, input logic [31:0] data, input logic [31:0] prio);
    spq_pkg::in_item_t item;
    item.cmd         = cmd;
    item.in_data     = data;
    item.in_priority = prio;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    if (tx_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      pause($urandom_range(1, 10));
    end
  endtask

  // hold the input until every expected result has come back
  task automatic drain_wait();
    pause(1);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_mixed(input int len, input int pmode, input int enq_bias);
    repeat (len) begin
      if ($urandom_range(0, 99) < enq_bias) begin
        send(spq_pkg::CMD_ENQ, pick_data(), pick_prio(pmode));
      end else begin
        send(spq_pkg::CMD_DEQ, $urandom, $urandom);
      end
    end
  endtask

  task automatic run_fill(input int len, input int pmode);
    repeat (len) send(spq_pkg::CMD_ENQ, pick_data(), pick_prio(pmode));
  endtask

  task automatic run_drain(input int len);
    repeat (len) send(spq_pkg::CMD_DEQ, $urandom, $urandom);
  endtask

  // receiver: random ready bursts, one long hold on request, none in the tail
  initial begin : receiver
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (quiet_tail) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          stall_left = $urandom_range(1, 10);
          run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
        end
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
          run_left--;
        end
        @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int  kind;
    bit  pressed;
    pressed = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty dequeue, extreme priorities and data, ties, signed order
    send(spq_pkg::CMD_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(spq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 32'h0000_0000);
    send(spq_pkg::CMD_ENQ, 32'h8000_0000, 32'h0000_0000);
    send(spq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 32'h8000_0000);
    send(spq_pkg::CMD_ENQ, 32'h0000_0000, 32'h7FFF_FFFF);
    send(spq_pkg::CMD_ENQ, 32'h1234_5678, 32'hFFFF_FFFF);
    send(spq_pkg::CMD_ENQ, 32'hA5A5_A5A5, 32'h7FFF_FFFF);
    run_drain(7);
    send(spq_pkg::CMD_DEQ, 32'h0, 32'h0);

    // full queue and rejected enqueues right away
    run_fill(DEPTH + 2, 1);
    run_drain(DEPTH + 2);

    while (n_sent < 880) begin
      if (!pressed && n_sent >= 400) begin
        pressed  = 1'b1;
        hold_req = 1'b1;
        run_fill(24, 0);
        run_mixed(16, 1, 40);
        drain_wait();
      end
      kind    = $urandom_range(0, 9);
      tx_gaps = ($urandom_range(0, 2) != 0);
      if (kind < 4) begin
        run_mixed($urandom_range(10, 40), $urandom_range(0, 2), $urandom_range(30, 70));
      end else if (kind < 7) begin
        run_fill($urandom_range(DEPTH, DEPTH + 4), $urandom_range(0, 2));
      end else begin
        run_drain($urandom_range(DEPTH - 2, DEPTH + 4));
      end
    end

    // back-to-back tail, no idling on either side
    quiet_tail = 1'b1;
    run_fill(DEPTH + 2, 1);
    run_drain(DEPTH + 2);
    run_mixed(60, 0, 55);
    run_fill(DEPTH + 1, 2);
    run_mixed(40, 1, 45);

    drain_wait();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
